// ----- rtl/nmea_pkg.sv -----
// Package for the NMEA coordinate parser: widths, character codes, sequencer states.
`default_nettype none
package nmea_pkg;

  localparam int     MAX_LEN_DEF = 11;
  localparam int     INT_DIG_W   = 3;
  localparam int     INT_DIG_MIN = 4;
  localparam int     INT_DIG_MAX = 5;
  localparam int     INT_DIG_SAT = 6;
  localparam int     DEG_W       = 10;
  localparam int     MD_W        = 30;
  localparam int     QW          = 21;
  localparam int     SW          = $clog2(QW);
  localparam int     SCALE_STEPS = 6;
  localparam longint MICRO       = 1000000;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCALE,
    ST_DIV,
    ST_DONE
  } state_t;

  function automatic longint pow10(input int n);
    longint r;
    r = 1;
    for (int k = 0; k < n; k++) r = r * 10;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/nmea_coordinate_to_microdegrees.sv -----
// NMEA ddmm.mmmm / dddmm.mmmm string to micro-degrees, shared add/subtract unit.
//
// Request channel: ch, last with ch_valid / ch_ready. One character per cycle
// while the parser is idle; last marks the end of the string.
// Result channel: ok, micro_degrees with res_valid / res_ready. One result per
// string, held in an output register until taken.
// After the last character ch_ready drops. A rejected string goes from the
// check state straight to the final state; an accepted one passes one check,
// 6 multiply-by-ten steps and 21 restoring-division steps, the latter two on one
// shared adder/subtractor, before the output register is loaded.
// Characters of the next string are taken while a result waits in the output
// register; if the receiver still stalls when the next result is ready, the
// sequencer holds in its final state and ch_ready stays low.
// Reset (synchronous, active high) clears the parser and drops res_valid.
`default_nettype none
module nmea_coordinate_to_microdegrees
  import nmea_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            ch_valid,
  output logic                 ch_ready,
  input  wire logic [7:0]      ch,
  input  wire logic            last,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output logic                 ok,
  output logic [MD_W-1:0]      micro_degrees
);

  localparam int     CW        = $clog2(MAX_LEN + 2);
  localparam int     FRAC_MAX  = MAX_LEN - 5;
  localparam longint SCALE_MAX = pow10(FRAC_MAX);
  localparam int     NW        = $clog2(100 * SCALE_MAX);
  localparam int     DW        = $clog2(60 * SCALE_MAX + 1);
  localparam int     PW        = $clog2(100 * SCALE_MAX * MICRO);

  state_t state, state_next;

  logic [CW-1:0]        cnt;
  logic                 seen_point;
  logic                 bad;
  logic [INT_DIG_W-1:0] idig;
  logic [DEG_W-1:0]     deg;
  logic [3:0]           prev1, prev2;
  logic [NW-1:0]        n;
  logic [DW-1:0]        dv;
  logic                 okr;
  logic [PW-1:0]        p, ds;
  logic [QW-1:0]        q;
  logic [SW-1:0]        step;

  logic                 acc;
  logic [CW-1:0]        cnt_inc;
  logic                 in_range, is_digit, is_point;
  logic [3:0]           d;
  logic                 eval_ok;
  logic                 load_out;
  logic [PW:0]          add_a, add_b, add_sum;
  logic                 add_cin;

  assign acc      = ch_valid && ch_ready;
  assign cnt_inc  = (cnt <= CW'(MAX_LEN)) ? cnt + CW'(1) : cnt;
  assign in_range = cnt_inc <= CW'(MAX_LEN);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_point = (ch == CH_POINT) && !seen_point;
  assign d        = ch[3:0];
  assign eval_ok  = !bad && (cnt <= CW'(MAX_LEN)) &&
                    ((idig == INT_DIG_W'(INT_DIG_MIN)) || (idig == INT_DIG_W'(INT_DIG_MAX)));
  assign load_out = (state == ST_DONE) && (!res_valid || res_ready);

  // shared unit: x*10 as (x<<3)+(x<<1), or p - ds with carry as the compare
  always_comb begin
    if (state == ST_SCALE) begin
      add_a   = {1'b0, PW'(p << 3)};
      add_b   = {1'b0, PW'(p << 1)};
      add_cin = 1'b0;
    end else begin
      add_a   = {1'b0, p};
      add_b   = {1'b0, ~ds};
      add_cin = 1'b1;
    end
    add_sum = add_a + add_b + (PW+1)'(add_cin);
  end

  always_comb begin
    state_next = state;
    ch_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        ch_ready = 1'b1;
        if (ch_valid && last) state_next = ST_EVAL;
      end
      ST_EVAL:  state_next = eval_ok ? ST_SCALE : ST_DONE;
      ST_SCALE: if (step == '0) state_next = ST_DIV;
      ST_DIV:   if (step == '0) state_next = ST_DONE;
      ST_DONE:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst || load_out) begin
      cnt        <= '0;
      seen_point <= 1'b0;
      bad        <= 1'b0;
      idig       <= '0;
      deg        <= '0;
      prev1      <= '0;
      prev2      <= '0;
      n          <= '0;
      dv         <= DW'(60);
    end else if (acc) begin
      cnt <= cnt_inc;
      if (is_point) begin
        seen_point <= 1'b1;
      end else if (is_digit) begin
        if (in_range) begin
          if (seen_point) begin
            n  <= NW'({n, 3'b0}) + NW'({n, 1'b0}) + NW'(d);
            dv <= DW'({dv, 3'b0}) + DW'({dv, 1'b0});
          end else if (idig < INT_DIG_W'(INT_DIG_MAX)) begin
            if (idig >= INT_DIG_W'(2)) begin
              deg <= DEG_W'({deg, 3'b0}) + DEG_W'({deg, 1'b0}) + DEG_W'(prev2);
            end
            prev2 <= prev1;
            prev1 <= d;
            n     <= NW'({prev1, 3'b0}) + NW'({prev1, 1'b0}) + NW'(d);
            idig  <= idig + INT_DIG_W'(1);
          end else begin
            idig <= INT_DIG_W'(INT_DIG_SAT);
          end
        end
      end else begin
        bad <= 1'b1;
      end
    end
  end

  // arithmetic sequence
  always_ff @(posedge clk) begin
    case (state)
      ST_EVAL: begin
        okr  <= eval_ok;
        p    <= PW'(n);
        ds   <= PW'(dv) << (QW - 1);
        q    <= '0;
        step <= SW'(SCALE_STEPS - 1);
      end
      ST_SCALE: begin
        p    <= add_sum[PW-1:0];
        step <= (step == '0) ? SW'(QW - 1) : step - SW'(1);
      end
      ST_DIV: begin
        if (add_sum[PW]) p <= add_sum[PW-1:0];
        q    <= {q[QW-2:0], add_sum[PW]};
        ds   <= ds >> 1;
        step <= step - SW'(1);
      end
      default: begin
        step <= step;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ok            <= okr;
      micro_degrees <= okr ? (MD_W'(deg) * MD_W'(MICRO) + MD_W'(q)) : '0;
    end
  end

  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !ok) |-> (micro_degrees == '0))
    else $error("rejected result carries a nonzero value");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (micro_degrees <= MD_W'(1000666667)))
    else $error("result above largest coordinate");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, p} < {ds, 1'b0}))
    else $error("division remainder out of bound");

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (ch_valid && ch_ready && last) |=> !ch_ready)
    else $error("request taken right after final character");

endmodule
`default_nettype wire

// ----- test/coord_result_check.sv -----
// Result checker for the NMEA coordinate parser: predicts each string's result and compares.
module coord_result_check
  import nmea_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            ch_valid,
  input  logic            ch_ready,
  input  logic [7:0]      ch,
  input  logic            last,
  input  logic            res_valid,
  input  logic            res_ready,
  input  logic            ok,
  input  logic [MD_W-1:0] micro_degrees,
  output int              mismatches,
  output int              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            ok;
    logic [MD_W-1:0] md;
  } coord_t;

  coord_t expected_coords[$];

  logic [16:0] int_sum;
  logic [19:0] frac_sum;
  logic [3:0]  int_cnt;
  logic [2:0]  frac_cnt;
  logic [3:0]  len_cnt;
  logic        have_point;
  logic        saw_bad;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic clear_parse();
    int_sum = '0;
    frac_sum = '0;
    int_cnt = '0;
    frac_cnt = '0;
    len_cnt = '0;
    have_point = 1'b0;
    saw_bad = 1'b0;
  endtask

  // exact D + (M * 10^n + F) / (60 * 10^n) degrees, times one million, truncated
  function automatic logic [MD_W-1:0] coord_microdeg();
    longint unsigned scale, whole, mins, num;
    scale = 1;
    for (int k = 0; k < frac_cnt; k++) scale = scale * 10;
    whole = int_sum / 100;
    mins = int_sum % 100;
    num = (mins * scale + frac_sum) * MICRO;
    return MD_W'(whole * MICRO + num / (60 * scale));
  endfunction

  task automatic parse_char(input logic [7:0] c, input logic fin);
    coord_t     res;
    logic [3:0] dig;
    dig = c[3:0];
    if (len_cnt <= MAX_LEN) len_cnt = len_cnt + 1'b1;
    if (c == CH_POINT && !have_point) begin
      have_point = 1'b1;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      // digits past the length limit are dropped
      if (len_cnt <= MAX_LEN) begin
        if (have_point) begin
          frac_sum = 20'(frac_sum * 20'd10 + 20'(dig));
          frac_cnt = frac_cnt + 1'b1;
        end else if (int_cnt < INT_DIG_MAX) begin
          int_sum = 17'(int_sum * 17'd10 + 17'(dig));
          int_cnt = int_cnt + 1'b1;
        end else begin
          int_cnt = 4'(INT_DIG_SAT);
        end
      end
    end else begin
      saw_bad = 1'b1;
    end
    if (fin) begin
      res.ok = !saw_bad && len_cnt <= MAX_LEN &&
               (int_cnt == INT_DIG_MIN || int_cnt == INT_DIG_MAX);
      res.md = res.ok ? coord_microdeg() : '0;
      expected_coords.push_back(res);
      clear_parse();
    end
  endtask

  always @(posedge clk) begin
    coord_t want;
    if (rst) begin
      clear_parse();
      expected_coords.delete();
      outstanding <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_coords.size() == 0) begin
          report_mismatch("result with no request pending", micro_degrees, 0);
        end else begin
          want = expected_coords.pop_front();
          if (ok !== want.ok) report_mismatch("ok", ok, want.ok);
          if (micro_degrees !== want.md) report_mismatch("micro_degrees", micro_degrees, want.md);
        end
      end
      if (ch_valid && ch_ready) parse_char(ch, last);
      outstanding <= expected_coords.size();
    end
  end

endmodule

// ----- test/testbench.sv -----
// Testbench top for the NMEA coordinate parser: clock, reset, stimulus, watchdog and verdict.
module testbench
  import nmea_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REQUESTS    = 650;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 150;
  localparam int TAIL_CYCLES = 40;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            ch_valid = 1'b0;
  logic            ch_ready;
  logic [7:0]      ch = '0;
  logic            last = 1'b0;
  logic            res_valid;
  logic            res_ready = 1'b0;
  logic            ok;
  logic [MD_W-1:0] micro_degrees;

  int mismatches;
  int outstanding;
  int sent_chars = 0;
  int idle_cycles = 0;
  bit held_once = 1'b0;
  logic [7:0] chars[$];

  always #5 clk = ~clk;

  nmea_coordinate_to_microdegrees dut (
    .clk(clk),
    .rst(rst),
    .ch_valid(ch_valid),
    .ch_ready(ch_ready),
    .ch(ch),
    .last(last),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .ok(ok),
    .micro_degrees(micro_degrees)
  );

  coord_result_check scoreboard (
    .clk(clk),
    .rst(rst),
    .ch_valid(ch_valid),
    .ch_ready(ch_ready),
    .ch(ch),
    .last(last),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .ok(ok),
    .micro_degrees(micro_degrees),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // mostly short, now and then long
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [7:0] rand_digit();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return CH_ZERO;
    if (r < 4) return CH_NINE;
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin);
    ch_valid <= 1'b1;
    ch <= c;
    last <= fin;
    @(posedge clk);
    while (!ch_ready) @(posedge clk);
    sent_chars++;
  endtask

  task automatic send_string();
    int n;
    bit quiet;
    quiet = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < chars.size(); i++) begin
      send_char(chars[i], i == chars.size() - 1);
      n = quiet ? 0 : pause_len();
      if (n > 0) begin
        ch_valid <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  task automatic send_text(input string t);
    chars.delete();
    for (int i = 0; i < t.len(); i++) chars.push_back(t[i]);
    send_string();
  endtask

  // sender holds off until every result is back
  task automatic drain();
    ch_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic make_coordinate_text();
    int n_int, n_frac, n;
    chars.delete();
    if ($urandom_range(0, 9) < 7) begin
      n_int = ($urandom_range(0, 9) < 8) ? $urandom_range(4, 5) : $urandom_range(0, 7);
      for (int i = 0; i < n_int; i++) chars.push_back(rand_digit());
      if ($urandom_range(0, 9) < 8) begin
        chars.push_back(CH_POINT);
        n_frac = $urandom_range(0, MAX_LEN_DEF - n_int - 1);
        if ($urandom_range(0, 9) == 0) n_frac = n_frac + $urandom_range(1, 3);
        for (int i = 0; i < n_frac; i++) chars.push_back(rand_digit());
      end
      if (chars.size() == 0) chars.push_back(rand_digit());
      if ($urandom_range(0, 9) == 0)
        chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      n = $urandom_range(1, 14);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: chars.push_back(8'($urandom_range(0, 255)));
          5, 6, 7:       chars.push_back(rand_digit());
          default:       chars.push_back(CH_POINT);
        endcase
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_text("0000");          // four digits, no point, lowest value
    send_text("99999.99999");   // highest value at the length limit
    send_text("1260.");         // trailing point, minutes of sixty
    send_text("12..");          // second point, short integer part
    send_text("123456789012");  // one character too long
    chars.delete();
    chars.push_back(8'h00);     // NUL byte
    send_string();
    drain();

    while (sent_chars < REQUESTS) begin
      make_coordinate_text();
      send_string();
      if ($urandom_range(0, 29) == 0) drain();
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // result side: ready stretches, random stalls, one long hold to back up the block
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_once && sent_chars >= HOLD_AFTER) begin
        held_once = 1'b1;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 9) < 2) begin
        res_ready <= 1'b1;
        repeat ($urandom_range(10, 80)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        n = pause_len();
        if (n > 0) begin
          res_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (ch_valid && ch_ready) || (res_valid && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
